// ===== rtl/cspc_pkg.sv =====
// Shared types and constants for the circle set placement checker.
// No dependencies; every other file in rtl/ imports this package.
package cspc_pkg;

  localparam int MAX_CIRCLES = 64;
  localparam int MAX_ZONES   = 16;

  localparam int COORD_W = 16;
  localparam int RAD_W   = 15;

  localparam int CAW    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int ZAW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CCNT_W = $clog2(MAX_CIRCLES + 1);
  localparam int ZCNT_W = $clog2(MAX_ZONES + 1);
  localparam int SCAN_W = (CCNT_W > ZCNT_W) ? CCNT_W : ZCNT_W;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] KIND_ZONE   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_MAX_Y = 2'd3;

  // Sticky failure flag positions.
  localparam int FLAG_BOUNDS  = 0;
  localparam int FLAG_OVERLAP = 1;
  localparam int FLAG_EXCL    = 2;
  localparam int FLAG_OVF     = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RAD_W-1:0]   rad;
  } cspc_circ_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } cspc_zone_t;

  // The circle under test, held steady for the whole scan.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [RAD_W-1:0]   inner;
    logic        [RAD_W-1:0]   outer;
  } cspc_probe_t;

endpackage

// ===== rtl/cspc_circle_unit.sv =====
// Circle store and outer radius overlap test, one stored circle per cycle.
// Depends on cspc_pkg.
module cspc_circle_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [cspc_pkg::CAW-1:0]    wr_addr,
  input  cspc_pkg::cspc_circ_t        wr_data,
  input  logic                        rd_en,
  input  logic [cspc_pkg::CAW-1:0]    rd_addr,
  input  cspc_pkg::cspc_probe_t       probe,
  output logic                        hit
);
  import cspc_pkg::*;

  cspc_circ_t mem [MAX_CIRCLES];
  cspc_circ_t rd_data_r;
  logic       v1_r, v2_r, v3_r;

  logic signed [COORD_W:0]   dx_r, dy_r;
  logic        [RAD_W:0]     sum_r;
  logic        [31:0]        dx2_r, dy2_r, s2_r;
  logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
  logic        [2*RAD_W+1:0] s_sq;
  logic        [32:0]        dist2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;
  assign s_sq  = sum_r * sum_r;

  always_ff @(posedge clk) begin
    dx_r  <= (COORD_W+1)'(probe.x) - (COORD_W+1)'(rd_data_r.x);
    dy_r  <= (COORD_W+1)'(probe.y) - (COORD_W+1)'(rd_data_r.y);
    sum_r <= {1'b0, probe.outer} + {1'b0, rd_data_r.rad};
    dx2_r <= dx_sq[31:0];
    dy2_r <= dy_sq[31:0];
    s2_r  <= s_sq[31:0];
  end

  // Touching circles pass; only a strictly shorter distance overlaps.
  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit   = v3_r && (dist2 < {1'b0, s2_r});

endmodule

// ===== rtl/cspc_zone_unit.sv =====
// Exclusion rectangle store and inner radius clearance test.
// Depends on cspc_pkg.
module cspc_zone_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [cspc_pkg::ZAW-1:0]    wr_addr,
  input  cspc_pkg::cspc_zone_t        wr_data,
  input  logic                        rd_en,
  input  logic [cspc_pkg::ZAW-1:0]    rd_addr,
  input  cspc_pkg::cspc_probe_t       probe,
  output logic                        hit
);
  import cspc_pkg::*;

  cspc_zone_t mem [MAX_ZONES];
  cspc_zone_t rd_data_r;
  logic       v1_r, v2_r, v3_r;

  logic signed [COORD_W:0]   lo_x, hi_x, lo_y, hi_y, mx_x, mx_y;
  logic        [COORD_W-1:0] dx_r, dy_r;
  logic        [31:0]        dx2_r, dy2_r;
  logic        [2*RAD_W-1:0] r2_r;
  logic        [32:0]        dist2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Clamped distance from the centre to the rectangle along each axis.
  always_comb begin
    lo_x = (COORD_W+1)'(rd_data_r.min_x) - (COORD_W+1)'(probe.x);
    hi_x = (COORD_W+1)'(probe.x) - (COORD_W+1)'(rd_data_r.max_x);
    lo_y = (COORD_W+1)'(rd_data_r.min_y) - (COORD_W+1)'(probe.y);
    hi_y = (COORD_W+1)'(probe.y) - (COORD_W+1)'(rd_data_r.max_y);
    mx_x = (hi_x > lo_x) ? hi_x : lo_x;
    mx_y = (hi_y > lo_y) ? hi_y : lo_y;
  end

  always_ff @(posedge clk) begin
    dx_r  <= mx_x[COORD_W] ? '0 : mx_x[COORD_W-1:0];
    dy_r  <= mx_y[COORD_W] ? '0 : mx_y[COORD_W-1:0];
    dx2_r <= dx_r * dx_r;
    dy2_r <= dy_r * dy_r;
    r2_r  <= probe.inner * probe.inner;
  end

  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit   = v3_r && (dist2 < 33'(r2_r));

endmodule

// ===== rtl/circle_set_placement_check.sv =====
// Top level of the circle set placement checker: sequencer, flags, config.
// Depends on cspc_pkg, cspc_circle_unit and cspc_zone_unit.
//
// A rectangle (tuser 0) or a clear (tuser 2) is taken in the idle state. A circle
// (tuser 1) is tested against the bounds at acceptance and written into the
// circle store. The sequencer then walks both stores together, one entry per
// cycle, over N = max(earlier stored circles, stored rectangles) entries. It then
// passes through the drain state, which lets the compare pipelines empty, and
// the finish state, which takes the verdict. No new item is accepted until the
// circle is through the finish state and the sequencer is idle again.
// A circle with tlast high returns one word with the verdict, after which
// the circle set and the flags are cleared; rectangles stay until a clear.
// The output word is registered, so a verdict may wait on out_tready while
// rectangles and unmarked circles keep flowing in. A marked circle holds in
// its last cycle for as long as an earlier verdict is still unread.
module circle_set_placement_check (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // zone_min_x[15:0], zone_min_y[31:16], zone_max_x[47:32], zone_max_y[63:48],
  // center_x[79:64], center_y[95:80], inner_radius[110:96],
  // outer_radius[125:111], zero fill[127:126]
  input  logic [cspc_pkg::IN_DATA_W-1:0]       in_tdata,
  // kind[1:0]
  input  logic [1:0]                           in_tuser,
  // last_circle
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // placeable[0], bounds_fail[1], overlap_fail[2], exclusion_fail[3],
  // overflow[4], zero fill[7:5]
  output logic [cspc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cspc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cspc_pkg::COORD_W-1:0]         cfg_data
);
  import cspc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  localparam int DRAIN_LEN = 3;

  state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic [CCNT_W-1:0] ccount_r, ccount_nxt, clim_r, clim_nxt;
  logic [ZCNT_W-1:0] zcount_r, zcount_nxt;
  logic [SCAN_W-1:0] idx_r, idx_nxt;
  logic [1:0]        drain_r, drain_nxt;
  logic [3:0]        flags_r, flags_nxt;
  logic              last_r, last_nxt;
  cspc_probe_t       probe_r, probe_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        out_r, out_nxt;

  logic        in_acc;
  cspc_probe_t in_probe;
  cspc_zone_t  in_zone;
  cspc_circ_t  in_circ;
  logic        bound_bad;
  logic        circ_we, zone_we;
  logic        c_rd, z_rd, scan_done;
  logic        ov_hit, ex_hit;
  logic signed [COORD_W+1:0] x_lo, x_hi, y_lo, y_hi;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign in_zone.min_x  = in_tdata[15:0];
  assign in_zone.min_y  = in_tdata[31:16];
  assign in_zone.max_x  = in_tdata[47:32];
  assign in_zone.max_y  = in_tdata[63:48];
  assign in_probe.x     = in_tdata[79:64];
  assign in_probe.y     = in_tdata[95:80];
  assign in_probe.inner = in_tdata[110:96];
  assign in_probe.outer = in_tdata[125:111];
  assign in_circ.x      = in_probe.x;
  assign in_circ.y      = in_probe.y;
  assign in_circ.rad    = in_probe.outer;

  // Inner radius against the drawing bounds, exact in 18 bits.
  always_comb begin
    x_lo = (COORD_W+2)'(in_probe.x) - (COORD_W+2)'({1'b0, in_probe.inner});
    x_hi = (COORD_W+2)'(in_probe.x) + (COORD_W+2)'({1'b0, in_probe.inner});
    y_lo = (COORD_W+2)'(in_probe.y) - (COORD_W+2)'({1'b0, in_probe.inner});
    y_hi = (COORD_W+2)'(in_probe.y) + (COORD_W+2)'({1'b0, in_probe.inner});
    bound_bad = (x_lo < (COORD_W+2)'(min_x_r)) || (x_hi > (COORD_W+2)'(max_x_r)) ||
                (y_lo < (COORD_W+2)'(min_y_r)) || (y_hi > (COORD_W+2)'(max_y_r));
  end

  assign circ_we = in_acc && (in_tuser == KIND_CIRCLE) &&
                   (ccount_r < CCNT_W'(MAX_CIRCLES));
  assign zone_we = in_acc && (in_tuser == KIND_ZONE) &&
                   (zcount_r < ZCNT_W'(MAX_ZONES));

  // The new circle sits at index clim_r, which the scan never reaches, so
  // the store write needs no interlock against the reads that follow.
  assign c_rd      = (state_r == ST_SCAN) && (idx_r < SCAN_W'(clim_r));
  assign z_rd      = (state_r == ST_SCAN) && (idx_r < SCAN_W'(zcount_r));
  assign scan_done = !(idx_r < SCAN_W'(clim_r)) && !(idx_r < SCAN_W'(zcount_r));

  cspc_circle_unit u_circ (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (circ_we),
    .wr_addr (ccount_r[CAW-1:0]),
    .wr_data (in_circ),
    .rd_en   (c_rd),
    .rd_addr (idx_r[CAW-1:0]),
    .probe   (probe_r),
    .hit     (ov_hit)
  );

  cspc_zone_unit u_zone (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (zone_we),
    .wr_addr (zcount_r[ZAW-1:0]),
    .wr_data (in_zone),
    .rd_en   (z_rd),
    .rd_addr (idx_r[ZAW-1:0]),
    .probe   (probe_r),
    .hit     (ex_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    ccount_nxt    = ccount_r;
    clim_nxt      = clim_r;
    zcount_nxt    = zcount_r;
    idx_nxt       = idx_r;
    drain_nxt     = drain_r;
    last_nxt      = last_r;
    probe_nxt     = probe_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    flags_nxt     = flags_r;
    flags_nxt[FLAG_OVERLAP] = flags_r[FLAG_OVERLAP] | ov_hit;
    flags_nxt[FLAG_EXCL]    = flags_r[FLAG_EXCL] | ex_hit;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            KIND_ZONE: begin
              if (zone_we) begin
                zcount_nxt = zcount_r + 1'b1;
              end else begin
                flags_nxt[FLAG_OVF] = 1'b1;
              end
            end
            KIND_CIRCLE: begin
              probe_nxt = in_probe;
              last_nxt  = in_tlast;
              clim_nxt  = ccount_r;
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
              if (bound_bad) begin
                flags_nxt[FLAG_BOUNDS] = 1'b1;
              end
              if (circ_we) begin
                ccount_nxt = ccount_r + 1'b1;
              end else begin
                flags_nxt[FLAG_OVF] = 1'b1;
              end
            end
            KIND_CLEAR: begin
              ccount_nxt = '0;
              zcount_nxt = '0;
              flags_nxt  = '0;
            end
            KIND_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == 2'(DRAIN_LEN - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_nxt       = {flags_r, (flags_r == 4'd0)};
          out_valid_nxt = 1'b1;
          ccount_nxt    = '0;
          flags_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ccount_r    <= '0;
      zcount_r    <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      min_x_r     <= '0;
      min_y_r     <= '0;
      max_x_r     <= COORD_W'(1023);
      max_y_r     <= COORD_W'(1023);
    end else begin
      state_r     <= state_nxt;
      ccount_r    <= ccount_nxt;
      zcount_r    <= zcount_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BOUND_MIN_X: min_x_r <= cfg_data;
          REG_BOUND_MIN_Y: min_y_r <= cfg_data;
          REG_BOUND_MAX_X: max_x_r <= cfg_data;
          REG_BOUND_MAX_Y: max_y_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    clim_r  <= clim_nxt;
    idx_r   <= idx_nxt;
    drain_r <= drain_nxt;
    last_r  <= last_nxt;
    probe_r <= probe_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-5)'(0), out_r};

  // Compare hits only come back while the sequencer waits for them.
  a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_hit || ex_hit) |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("store compare hit outside of a scan");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == 4'd0)))
    else $error("placeable disagrees with failure flags");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ccount_r <= CCNT_W'(MAX_CIRCLES)) && (zcount_r <= ZCNT_W'(MAX_ZONES)))
    else $error("store fill count out of range");

  a_finish_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && $past(state_r) != ST_FINISH) |->
      ($past(state_r) == ST_DRAIN))
    else $error("verdict taken before the compare pipelines emptied");

endmodule
